// ===== rtl/core/fss_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fss_pkg
// Shared types and constants of the fuzzy subsequence scorer.
// ============================================================================
package fss_pkg;

    // Command carried by each input word.
    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,   // append one pattern character
        MODE_TEXT   = 2'd1,   // score one text character
        MODE_END    = 2'd2,   // end of text, emit one result
        MODE_CLEAR  = 2'd3    // drop the pattern and the match state
    } t_mode;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam int         RUN_WEIGHT = 10;

    // The tail counter is a fixed 13-bit saturating counter.
    localparam int              TAIL_W   = 13;
    localparam logic [TAIL_W-1:0] TAIL_MAX = {TAIL_W{1'b1}};

endpackage

// ===== rtl/core/fss_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fss_if
// Valid/ready channels of the scorer: input word and result word.
// ============================================================================
interface fss_in_if;
    logic              valid;
    logic              ready;
    fss_pkg::t_mode    mode;
    logic [7:0]        ch;

    modport source (output valid, output mode, output ch, input ready);
    modport sink   (input valid, input mode, input ch, output ready);
endinterface

interface fss_out_if #(
    parameter int SCORE_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          matched;
    logic signed [SCORE_WIDTH-1:0] score;

    modport source (output valid, output matched, output score, input ready);
    modport sink   (input valid, input matched, input score, output ready);
endinterface

// ===== rtl/core/fss_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fss_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fss_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fuzzy_subsequence_scorer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_subsequence_scorer_core
// Case-insensitive, space-ignoring subsequence scorer over a streamed text.
// ============================================================================
// The block takes one word per clock while no end-of-text word is stalled
// by the output side: each accepted word is held in an input register, its
// whole update (pattern append, one text-character compare and score step,
// or the final score) is computed combinationally from that register, and
// the end-of-text result is registered in an output register as the word
// retires from the input register. The pattern character under the match
// cursor comes out of a single-port-read RAM whose address is driven by the
// next cursor value, so it is ready when the next word arrives;
// an append to the very entry being fetched is forwarded around the RAM. The
// input side stalls only when an end-of-text word meets a full output
// register that is not being drained. The pattern store has no reset: only
// entries below the loaded length are ever compared. Scores saturate to the
// SCORE_WIDTH signed range and the tail count saturates at 8191.
// ============================================================================
module fuzzy_subsequence_scorer_core #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SCORE_WIDTH   = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fss_in_if.sink        i_in,
    fss_out_if.source     o_out
);

    import fss_pkg::*;

    localparam int PW = $clog2(PATTERN_DEPTH + 1);
    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int SW = SCORE_WIDTH;

    localparam logic [PW-1:0]        DEPTH_CNT = PW'(PATTERN_DEPTH);
    localparam logic signed [SW-1:0] SCORE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SCORE_MIN = {1'b1, {(SW-1){1'b0}}};

    // Clamp a one-bit-wider sum back into the score range.
    function automatic logic signed [SW-1:0] sat_score(input logic signed [SW:0] v);
        if (v[SW] != v[SW-1]) begin
            return v[SW] ? SCORE_MIN : SCORE_MAX;
        end
        return v[SW-1:0];
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // Input register.
    logic        r_in_valid, n_in_valid;
    t_mode       r_in_mode;
    logic [7:0]  r_in_ch;

    // Pattern and match state.
    logic [PW-1:0]        r_plen, n_plen;
    logic                 r_ovf, n_ovf;
    logic                 r_tsf, n_tsf;
    logic [PW-1:0]        r_mp, n_mp;
    logic [PW-1:0]        r_run, n_run;
    logic signed [SW-1:0] r_score, n_score;
    logic                 r_fin, n_fin;
    logic [TAIL_W-1:0]    r_tail, n_tail;
    logic                 r_armed, n_armed;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_matched, n_out_matched;
    logic signed [SW-1:0] r_out_score, n_out_score;

    // Forwarding of an append that hits the entry being fetched.
    logic       r_byp_valid, n_byp_valid;
    logic [7:0] r_byp_data;

    logic                 w_advance;
    logic                 w_take;
    logic                 w_we;
    logic [7:0]           w_rdata;
    logic [7:0]           w_pchar;
    logic                 w_pos_end;
    logic                 w_consumed;
    logic signed [SW:0]   w_score_ext;
    logic signed [SW:0]   w_gain;
    logic signed [SW:0]   w_run_ext;

    // The word in the input register retires unless it needs the output
    // register and that register is still full.
    assign w_advance  = r_in_valid &&
                        ((r_in_mode != MODE_END) || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_take     = i_in.valid && i_in.ready;

    assign w_pchar     = r_byp_valid ? r_byp_data : w_rdata;
    assign w_pos_end   = (r_mp >= r_plen);
    assign w_consumed  = r_fin || (w_pos_end && (!r_tsf || r_armed));
    assign w_score_ext = {r_score[SW-1], r_score};
    assign w_run_ext   = (SW+1)'(r_run);
    // Run weight of ten is formed as eight plus two; one point off on a case
    // difference.
    assign w_gain      = (w_run_ext <<< 3) + (w_run_ext <<< 1)
                       - (SW+1)'(r_in_ch != w_pchar);

    always_comb begin
        n_in_valid    = w_take || (r_in_valid && !w_advance);
        n_plen        = r_plen;
        n_ovf         = r_ovf;
        n_tsf         = r_tsf;
        n_mp          = r_mp;
        n_run         = r_run;
        n_score       = r_score;
        n_fin         = r_fin;
        n_tail        = r_tail;
        n_armed       = r_armed;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_matched = r_out_matched;
        n_out_score   = r_out_score;
        w_we          = 1'b0;

        if (w_advance) begin
            unique case (r_in_mode)
                MODE_APPEND: begin
                    if (r_in_ch == SPACE_CHAR) begin
                        n_tsf = 1'b1;
                    end else begin
                        n_tsf = 1'b0;
                        if (r_plen < DEPTH_CNT) begin
                            w_we   = 1'b1;
                            n_plen = r_plen + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                MODE_TEXT: begin
                    if (r_fin || (w_pos_end && !r_tsf)) begin
                        // Pattern fully consumed: every character is tail.
                        n_fin = 1'b1;
                        if (r_tail != TAIL_MAX) begin
                            n_tail = r_tail + 1'b1;
                        end
                    end else if (w_pos_end) begin
                        // A trailing pattern space waits for one more
                        // character; spaces here only arm the match.
                        if (r_in_ch == SPACE_CHAR) begin
                            n_armed = 1'b1;
                        end else begin
                            n_fin  = 1'b1;
                            n_tail = TAIL_W'(1);
                        end
                    end else if (r_in_ch != SPACE_CHAR) begin
                        if (fold_case(r_in_ch) == fold_case(w_pchar)) begin
                            n_score = sat_score(w_score_ext + w_gain);
                            n_run   = r_run + 1'b1;
                            n_mp    = r_mp + 1'b1;
                        end else begin
                            n_score = sat_score(w_score_ext - (SW+1)'(RUN_WEIGHT));
                            n_run   = '0;
                        end
                    end
                end
                MODE_END: begin
                    n_out_valid   = 1'b1;
                    n_out_matched = w_consumed && !r_ovf;
                    n_out_score   = (w_consumed && !r_ovf)
                                  ? sat_score(w_score_ext - (SW+1)'(r_tail))
                                  : '0;
                    n_mp    = '0;
                    n_run   = '0;
                    n_score = '0;
                    n_fin   = 1'b0;
                    n_tail  = '0;
                    n_armed = 1'b0;
                end
                MODE_CLEAR: begin
                    n_plen  = '0;
                    n_ovf   = 1'b0;
                    n_tsf   = 1'b0;
                    n_mp    = '0;
                    n_run   = '0;
                    n_score = '0;
                    n_fin   = 1'b0;
                    n_tail  = '0;
                    n_armed = 1'b0;
                end
                default: begin
                end
            endcase
        end

        n_byp_valid = w_we && (r_plen[AW-1:0] == n_mp[AW-1:0]);
    end

    // Pattern store: written at the fill count, read at the next cursor so
    // the entry is waiting when the next text character arrives.
    fss_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_DEPTH)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_plen[AW-1:0]),
        .i_wdata (r_in_ch),
        .i_raddr (n_mp[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_tsf       <= 1'b0;
            r_mp        <= '0;
            r_run       <= '0;
            r_score     <= '0;
            r_fin       <= 1'b0;
            r_tail      <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_plen      <= n_plen;
            r_ovf       <= n_ovf;
            r_tsf       <= n_tsf;
            r_mp        <= n_mp;
            r_run       <= n_run;
            r_score     <= n_score;
            r_fin       <= n_fin;
            r_tail      <= n_tail;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
            r_byp_valid <= n_byp_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_mode <= i_in.mode;
            r_in_ch   <= i_in.ch;
        end
        r_byp_data    <= r_in_ch;
        r_out_matched <= n_out_matched;
        r_out_score   <= n_out_score;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.matched = r_out_matched;
    assign o_out.score   = r_out_score;

endmodule

// ===== rtl/core/fss_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fss_checker
// Port-level checks of the scorer, bound to the top level.
// ============================================================================
module fss_checker #(
    parameter int SCORE_WIDTH = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_matched,
    input logic signed [SCORE_WIDTH-1:0] i_out_score
);

    // A held result word keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_matched) && $stable(i_out_score))
        else $error("result word changed while stalled");

    // An unmatched result always reports a zero score.
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_matched |-> i_out_score == '0)
        else $error("unmatched result with nonzero score");

    // With the output register empty the input side never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

endmodule

bind fuzzy_subsequence_scorer_core fss_checker #(
    .SCORE_WIDTH (SCORE_WIDTH)
) u_fss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_matched (o_out.matched),
    .i_out_score   (o_out.score)
);

// ===== test/fuzzy_subsequence_scorer_core_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_subsequence_scorer_core_test
// Self-checking bench for the fuzzy subsequence scorer core.
// ============================================================================
// A queue of input words is built up front. It holds a short directed part,
// then random pattern loads and texts that mostly contain the pattern, with
// some noise and broken runs mixed in. A clocked driver feeds the queue into
// the block with random idle cycles. The scoring rules are modelled inside
// the bench, and a clocked monitor compares every end-of-text result with the
// oldest predicted one, while it stalls the output side at random.
// ============================================================================
module fuzzy_subsequence_scorer_core_test;
    import fss_pkg::*;

    localparam int DEPTH   = 64;
    localparam int SCORE_W = 24;
    // Results are registered after the end-of-text word. Allow a margin.
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] ch;
    } t_word;

    typedef struct {
        bit                        matched;
        logic signed [SCORE_W-1:0] score;
    } t_score;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fss_in_if                          in_bus ();
    fss_out_if #(.SCORE_WIDTH(SCORE_W)) out_bus ();

    fuzzy_subsequence_scorer_core #(
        .PATTERN_DEPTH(DEPTH),
        .SCORE_WIDTH  (SCORE_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard state.
    // ------------------------------------------------------------------------
    t_word  word_q[$];      // words waiting to be driven
    t_score score_q[$];     // predicted results, oldest first
    logic [7:0] gen_pat[$]; // the generator's view of the loaded pattern
    int fail_count = 0;
    int cyc = 0;
    int n_append = 0, n_text = 0, n_clear = 0, n_results = 0, n_matched = 0;
    int n_overflowed = 0, n_tail_sat = 0;
    t_word  next_word;
    t_score due;

    // Predictor's copy of the block state.
    logic [7:0]        pat_mem [DEPTH];
    int unsigned       pat_len;
    bit                pat_ovf;
    bit                trail_sp;
    int unsigned       cursor;
    int unsigned       run_len;
    longint            acc_score;
    bit                done_f;
    logic [TAIL_W-1:0] tail_cnt;
    bit                tail_arm;

    // A long stretch in the middle of the run has no idling on either side.
    wire calm = (cyc >= 1200) && (cyc < 2000);

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic longint clamp_score(longint v);
        longint hi;
        hi = (longint'(1) <<< (SCORE_W - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    task automatic clear_match();
        cursor    = 0;
        run_len   = 0;
        acc_score = 0;
        done_f    = 1'b0;
        tail_cnt  = '0;
        tail_arm  = 1'b0;
    endtask

    // Advances the predicted state by one accepted word and queues a result
    // for an end-of-text word.
    task automatic apply_word(input t_mode mode, input logic [7:0] ch);
        t_score     res;
        bit         ok;
        logic [7:0] p;
        case (mode)
            MODE_APPEND: begin
                n_append++;
                if (ch == SPACE_CHAR) begin
                    trail_sp = 1'b1;
                end else begin
                    trail_sp = 1'b0;
                    if (pat_len < DEPTH) begin
                        pat_mem[pat_len] = ch;
                        pat_len++;
                    end else begin
                        pat_ovf = 1'b1;
                    end
                end
            end
            MODE_TEXT: begin
                n_text++;
                if (done_f || (cursor >= pat_len && !trail_sp)) begin
                    done_f = 1'b1;
                    if (tail_cnt != TAIL_MAX) tail_cnt++;
                end else if (cursor >= pat_len) begin
                    // Every pattern letter is in, the trailing space still
                    // waits for one more non-space text character.
                    if (ch == SPACE_CHAR) begin
                        tail_arm = 1'b1;
                    end else begin
                        done_f   = 1'b1;
                        tail_cnt = TAIL_W'(1);
                    end
                end else if (ch != SPACE_CHAR) begin
                    p = pat_mem[cursor];
                    if (fold_case(ch) == fold_case(p)) begin
                        acc_score = clamp_score(acc_score + longint'(run_len) * RUN_WEIGHT
                                                - ((ch != p) ? 1 : 0));
                        run_len++;
                        cursor++;
                    end else begin
                        acc_score = clamp_score(acc_score - RUN_WEIGHT);
                        run_len   = 0;
                    end
                end
            end
            MODE_CLEAR: begin
                n_clear++;
                pat_len  = 0;
                pat_ovf  = 1'b0;
                trail_sp = 1'b0;
                clear_match();
            end
            default: begin
                ok = (done_f || (cursor >= pat_len && (!trail_sp || tail_arm))) && !pat_ovf;
                res.matched = ok;
                res.score   = ok ? SCORE_W'(clamp_score(acc_score - longint'(tail_cnt)))
                                 : '0;
                score_q.push_back(res);
                n_results++;
                if (ok) n_matched++;
                if (pat_ovf) n_overflowed++;
                if (tail_cnt == TAIL_MAX) n_tail_sat++;
                clear_match();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_word(input t_mode mode, input logic [7:0] ch);
        t_word w;
        w.mode = mode;
        w.ch   = ch;
        word_q.push_back(w);
    endtask

    // Mostly letters of either case, some spaces, and any byte at all.
    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 25) return 8'h61 + 8'($urandom_range(25));
        if (r < 50) return 8'h41 + 8'($urandom_range(25));
        if (r < 60) return SPACE_CHAR;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] rand_pat_char();
        logic [7:0] c;
        c = rand_char();
        while (c == SPACE_CHAR) c = rand_char();
        return c;
    endfunction

    // Loads a pattern (or extends the current one) and streams a text in
    // which the pattern usually appears as a subsequence, then ends the text.
    task automatic well_formed_run();
        int         plen;
        int         k;
        int         j;
        logic [7:0] c;
        if ($urandom_range(99) < 70 || gen_pat.size() > 80) begin
            push_word(MODE_CLEAR, 8'($urandom_range(255)));
            gen_pat.delete();
        end
        plen = ($urandom_range(99) < 8) ? $urandom_range(60, 70) : $urandom_range(0, 12);
        for (k = 0; k < plen; k++) begin
            if ($urandom_range(99) < 10) push_word(MODE_APPEND, SPACE_CHAR);
            c = rand_pat_char();
            gen_pat.push_back(c);
            push_word(MODE_APPEND, c);
        end
        if ($urandom_range(99) < 25) begin
            push_word(MODE_APPEND, SPACE_CHAR);
            if ($urandom_range(1)) push_word(MODE_APPEND, SPACE_CHAR);
        end
        for (k = 0; k < gen_pat.size(); k++) begin
            for (j = $urandom_range(0, 2); j > 0; j--) push_word(MODE_TEXT, rand_char());
            // Now and then a pattern letter is left out, so the text may fail.
            if ($urandom_range(99) >= 4) begin
                c = gen_pat[k];
                if (fold_case(c) >= 8'h61 && fold_case(c) <= 8'h7A && $urandom_range(99) < 30)
                    c = c ^ 8'h20;
                push_word(MODE_TEXT, c);
            end
            // The pattern sometimes grows while the text is running.
            if (k == 1 && $urandom_range(99) < 10) begin
                c = rand_pat_char();
                gen_pat.push_back(c);
                push_word(MODE_APPEND, c);
            end
        end
        for (j = $urandom_range(0, 4); j > 0; j--) push_word(MODE_TEXT, rand_char());
        push_word(MODE_END, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // Input driver: one nonblocking update of valid per edge, so a word that
    // follows an accepted one keeps valid high without a glitch.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) apply_word(in_bus.mode, in_bus.ch);
            if (!in_bus.valid || in_bus.ready) begin
                if (word_q.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
                    next_word = word_q.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.mode  <= next_word.mode;
                    in_bus.ch    <= next_word.ch;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (score_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: matched=%0d score=%0d",
                                 $realtime, out_bus.matched, out_bus.score);
                end else begin
                    due = score_q.pop_front();
                    if (out_bus.matched !== due.matched || out_bus.score !== due.score) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result mismatch: matched exp=%0d got=%0d, %s%0d %s%0d",
                                     $realtime, due.matched, out_bus.matched,
                                     "score exp=", due.score, "got=", out_bus.score);
                    end
                end
            end
            out_bus.ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int k;
        bit long_done;
        long_done     = 1'b0;
        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.mode   = MODE_APPEND;
        in_bus.ch     = 8'h00;
        out_bus.ready = 1'b0;
        pat_len  = 0;
        pat_ovf  = 1'b0;
        trail_sp = 1'b0;
        clear_match();

        // Empty pattern: the text is all tail and the result is matched.
        push_word(MODE_END, 8'hFF);
        push_word(MODE_TEXT, 8'h78);
        push_word(MODE_TEXT, 8'h00);
        push_word(MODE_END, 8'h00);
        // Pattern with a trailing space: the first end is still short of one
        // character, a following space arms the match, then a tail counts.
        push_word(MODE_APPEND, 8'h61);
        push_word(MODE_APPEND, SPACE_CHAR);
        push_word(MODE_TEXT, 8'h41);
        push_word(MODE_END, 8'h55);
        push_word(MODE_TEXT, 8'h61);
        push_word(MODE_TEXT, SPACE_CHAR);
        push_word(MODE_END, 8'hAA);
        push_word(MODE_TEXT, 8'h61);
        push_word(MODE_TEXT, 8'h7A);
        push_word(MODE_TEXT, 8'hFF);
        push_word(MODE_END, 8'h00);
        // Pattern made of spaces only.
        push_word(MODE_CLEAR, 8'hFF);
        push_word(MODE_APPEND, SPACE_CHAR);
        push_word(MODE_APPEND, SPACE_CHAR);
        push_word(MODE_TEXT, SPACE_CHAR);
        push_word(MODE_TEXT, 8'h71);
        push_word(MODE_END, 8'h0F);
        // Byte extremes as pattern letters, with a mismatch on the way.
        push_word(MODE_CLEAR, 8'h00);
        push_word(MODE_APPEND, 8'hFF);
        push_word(MODE_APPEND, 8'h00);
        push_word(MODE_TEXT, 8'h00);
        push_word(MODE_TEXT, 8'hFF);
        push_word(MODE_TEXT, 8'h00);
        push_word(MODE_END, 8'hF0);

        while (word_q.size() < 1900) begin
            k = $urandom_range(99);
            if (k < 60) begin
                well_formed_run();
            end else if (k < 80) begin
                // A text against whatever pattern is loaded.
                for (k = $urandom_range(1, 8); k > 0; k--) push_word(MODE_TEXT, rand_char());
                push_word(MODE_END, 8'($urandom_range(255)));
            end else begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                    push_word(t_mode'($urandom_range(3)), 8'($urandom_range(255)));
            end
            // One long text runs the tail counter far past its usual range.
            if (!long_done && word_q.size() > 900) begin
                long_done = 1'b1;
                push_word(MODE_CLEAR, 8'h5A);
                push_word(MODE_APPEND, 8'h6B);
                push_word(MODE_TEXT, 8'h4B);
                for (k = 0; k < 300; k++) push_word(MODE_TEXT, rand_char());
                push_word(MODE_END, 8'h3C);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() > 0 || in_bus.valid || score_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pattern, %0d text and %0d clear words; %0d results, %0d matched.",
                 n_append, n_text, n_clear, n_results, n_matched);
        $display("%0d results came from an overflowed pattern, %0d with a saturated tail.",
                 n_overflowed, n_tail_sat);
        if (fail_count == 0 && score_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Timeout: the run did not drain in time.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fuzzy_subsequence_scorer_core.f =====
rtl/core/fss_pkg.sv
rtl/core/fss_if.sv
rtl/core/fss_ram.sv
rtl/core/fuzzy_subsequence_scorer_core.sv
rtl/core/fss_checker.sv
test/fuzzy_subsequence_scorer_core_test.sv
